>>> rtl/ir_pulse_width_frame_decoder_defines.svh
// Assertion helpers shared by the decoder RTL.
`ifndef IR_PULSE_WIDTH_FRAME_DECODER_DEFINES_SVH
`define IR_PULSE_WIDTH_FRAME_DECODER_DEFINES_SVH

// Condition and consequence checked in the same cycle.
`define IRPWD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Consequence checked in the cycle after the condition.
`define IRPWD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> rtl/irpwd_pkg.sv
`default_nettype none
package irpwd_pkg;

   localparam int unsigned WIDTH_W     = 16;
   localparam int unsigned CMD_W       = 8;
   localparam int unsigned CMD_POS_W   = 3;
   localparam int unsigned CMD_FIRST_BIT = 16;
   localparam int unsigned CMD_END_BIT   = 24;

   localparam logic [WIDTH_W-1:0] START_THR_RESET  = 16'd3000;
   localparam logic [WIDTH_W-1:0] REPEAT_THR_RESET = 16'd1700;
   localparam logic [WIDTH_W-1:0] ONE_THR_RESET    = 16'd900;
   localparam logic [WIDTH_W-1:0] ZERO_THR_RESET   = 16'd400;

   typedef enum logic [1:0] {
      KIND_COMMAND = 2'd0,
      KIND_REPEAT  = 2'd1,
      KIND_INVALID = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      REG_START  = 2'd0,
      REG_REPEAT = 2'd1,
      REG_ONE    = 2'd2,
      REG_ZERO   = 2'd3
   } reg_index_type;

   typedef enum logic {
      TOK_REPEAT = 1'b0,
      TOK_BIT    = 1'b1
   } token_kind_type;

   typedef struct packed {
      logic [WIDTH_W-1:0] start_thr;
      logic [WIDTH_W-1:0] repeat_thr;
      logic [WIDTH_W-1:0] one_thr;
      logic [WIDTH_W-1:0] zero_thr;
   } thresh_type;

   // One classified request handed from the front to the back.
   typedef struct packed {
      token_kind_type       kind;
      logic                 one;
      logic                 bad;
      logic                 cmd_en;
      logic [CMD_POS_W-1:0] cmd_pos;
      logic                 last;
   } token_type;

   typedef struct packed {
      logic in_frame;
      logic last_bit;
   } front_status_type;

endpackage
`default_nettype wire

>>> rtl/irpwd_req_if.sv
`default_nettype none
interface irpwd_req_if;
   logic                             valid;
   logic                             ready;
   logic [irpwd_pkg::WIDTH_W-1:0]    pulse_width;

   modport source (output valid, output pulse_width, input ready);
   modport sink   (input valid, input pulse_width, output ready);
endinterface
`default_nettype wire

>>> rtl/irpwd_rsp_if.sv
`default_nettype none
interface irpwd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     kind;
   logic [irpwd_pkg::CMD_W-1:0]    command;

   modport source (output valid, output kind, output command, input ready);
   modport sink   (input valid, input kind, input command, output ready);
endinterface
`default_nettype wire

>>> rtl/irpwd_front.sv
`default_nettype none
module irpwd_front #(
   parameter int unsigned FRAME_BITS = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   irpwd_req_if.sink                    req_ch,
   input  wire irpwd_pkg::thresh_type   thresh,
   output irpwd_pkg::token_type         push_token,
   output logic                         push_valid,
   input  wire                          push_ready,
   output irpwd_pkg::front_status_type  status
);

   localparam int unsigned IDX_W = $clog2(FRAME_BITS);

   logic             in_frame_ff, in_frame_in;
   logic [IDX_W-1:0] bit_idx_ff, bit_idx_in;
   logic [IDX_W-1:0] cmd_offset;
   logic             accept;
   logic             above_start, above_repeat, above_one, above_zero;
   logic             last_bit;

   assign req_ch.ready = push_ready;
   assign accept       = req_ch.valid && push_ready;

   assign above_start  = req_ch.pulse_width > thresh.start_thr;
   assign above_repeat = req_ch.pulse_width > thresh.repeat_thr;
   assign above_one    = req_ch.pulse_width > thresh.one_thr;
   assign above_zero   = req_ch.pulse_width > thresh.zero_thr;

   assign last_bit   = bit_idx_ff == IDX_W'(FRAME_BITS - 1);
   assign cmd_offset = bit_idx_ff - IDX_W'(irpwd_pkg::CMD_FIRST_BIT);

   always_comb begin
      push_token.kind    = in_frame_ff ? irpwd_pkg::TOK_BIT : irpwd_pkg::TOK_REPEAT;
      // The one test wins even when the thresholds are crossed.
      push_token.one     = above_one;
      push_token.bad     = !above_one && !above_zero;
      push_token.cmd_en  = (bit_idx_ff >= IDX_W'(irpwd_pkg::CMD_FIRST_BIT))
                           && (bit_idx_ff < IDX_W'(irpwd_pkg::CMD_END_BIT));
      push_token.cmd_pos = cmd_offset[irpwd_pkg::CMD_POS_W-1:0];
      push_token.last    = last_bit;
      // Idle requests that start a frame or are too short leave no token.
      push_valid = req_ch.valid && (in_frame_ff || (!above_start && above_repeat));
   end

   always_comb begin
      in_frame_in = in_frame_ff;
      bit_idx_in  = bit_idx_ff;
      if (accept) begin
         if (!in_frame_ff) begin
            if (above_start) begin
               in_frame_in = 1'b1;
               bit_idx_in  = '0;
            end
         end else if (last_bit) begin
            in_frame_in = 1'b0;
            bit_idx_in  = '0;
         end else begin
            bit_idx_in = bit_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         bit_idx_ff  <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         bit_idx_ff  <= bit_idx_in;
      end
   end

   assign status.in_frame = in_frame_ff;
   assign status.last_bit = last_bit;

endmodule
`default_nettype wire

>>> rtl/irpwd_queue.sv
`default_nettype none
module irpwd_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push_valid,
   input  wire irpwd_pkg::token_type push_token,
   output logic                    push_ready,
   output logic                    pop_valid,
   output irpwd_pkg::token_type    pop_token,
   input  wire                     pop
);

   irpwd_pkg::token_type mem_ff [2];
   logic                 wr_ptr_ff, rd_ptr_ff;
   logic [1:0]           count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_token  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_token;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/irpwd_back.sv
`default_nettype none
module irpwd_back (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       pop_valid,
   input  wire irpwd_pkg::token_type pop_token,
   output logic                      pop,
   irpwd_rsp_if.source               rsp_ch
);

   logic                          out_valid_ff, out_valid_in;
   irpwd_pkg::kind_type           out_kind_ff, out_kind_in;
   logic [irpwd_pkg::CMD_W-1:0]   out_cmd_ff, out_cmd_in;
   logic [irpwd_pkg::CMD_W-1:0]   cmd_ff, cmd_in;
   logic                          bad_ff, bad_in;
   logic [irpwd_pkg::CMD_W-1:0]   cmd_next;
   logic                          bad_next;

   assign pop = pop_valid && (!out_valid_ff || rsp_ch.ready);

   always_comb begin
      cmd_next = cmd_ff;
      if (pop_token.one && pop_token.cmd_en) begin
         cmd_next[pop_token.cmd_pos] = 1'b1;
      end
      bad_next = bad_ff || pop_token.bad;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_cmd_in   = out_cmd_ff;
      cmd_in       = cmd_ff;
      bad_in       = bad_ff;
      if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
      if (pop) begin
         unique case (pop_token.kind)
            irpwd_pkg::TOK_REPEAT: begin
               out_valid_in = 1'b1;
               out_kind_in  = irpwd_pkg::KIND_REPEAT;
               out_cmd_in   = '0;
            end
            irpwd_pkg::TOK_BIT: begin
               if (pop_token.last) begin
                  out_valid_in = 1'b1;
                  out_kind_in  = bad_next ? irpwd_pkg::KIND_INVALID
                                          : irpwd_pkg::KIND_COMMAND;
                  out_cmd_in   = bad_next ? '0 : cmd_next;
                  cmd_in       = '0;
                  bad_in       = 1'b0;
               end else begin
                  cmd_in = cmd_next;
                  bad_in = bad_next;
               end
            end
            default: begin
               out_valid_in = out_valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff <= out_kind_in;
      out_cmd_ff  <= out_cmd_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
         cmd_ff       <= '0;
         bad_ff       <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         cmd_ff       <= cmd_in;
         bad_ff       <= bad_in;
      end
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.kind    = out_kind_ff;
   assign rsp_ch.command = out_cmd_ff;

endmodule
`default_nettype wire

>>> rtl/ir_pulse_width_frame_decoder.sv
// Decoder for NEC-style IR remote frames that works on measured high-pulse
// widths in microseconds, one request per pulse. While idle, a pulse above
// the start threshold opens a frame and a shorter pulse above the repeat
// threshold yields a repeat result; other idle pulses are dropped. Inside a
// frame the next FRAME_BITS pulses are data bits, and the last one yields
// either the command byte (frame bits 16 to 23, least significant first) or
// an invalid-frame result if any bit was above neither the one nor the zero
// threshold. The block takes one request every clock cycle while the queue
// has room: the front compares the width against the four thresholds
// combinationally, a two-entry queue separates it from the back, and the
// back registers each result. There is no clearing pass after reset. The
// thresholds sit in four APB registers at byte addresses 0, 4, 8 and 12 and
// should only be written while no request is in flight.
`default_nettype none
`include "ir_pulse_width_frame_decoder_defines.svh"
module ir_pulse_width_frame_decoder #(
   parameter int unsigned FRAME_BITS = 32
) (
   input  wire          clock,
   input  wire          reset,
   irpwd_req_if.sink    req_ch,
   irpwd_rsp_if.source  rsp_ch,
   input  wire          csr_psel,
   input  wire          csr_penable,
   input  wire          csr_pwrite,
   input  wire  [3:0]   csr_paddr,
   input  wire  [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   // Threshold registers, written by a completed APB write access.
   irpwd_pkg::thresh_type thresh_ff, thresh_in;
   irpwd_pkg::reg_index_type csr_index;
   logic csr_write;

   irpwd_pkg::token_type        push_token, pop_token;
   logic                        push_valid, push_ready, pop_valid, pop;
   irpwd_pkg::front_status_type front_status;

   assign csr_pready = 1'b1;
   assign csr_index  = irpwd_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      thresh_in = thresh_ff;
      if (csr_write) begin
         unique case (csr_index)
            irpwd_pkg::REG_START:  thresh_in.start_thr  = csr_pwdata[15:0];
            irpwd_pkg::REG_REPEAT: thresh_in.repeat_thr = csr_pwdata[15:0];
            irpwd_pkg::REG_ONE:    thresh_in.one_thr    = csr_pwdata[15:0];
            irpwd_pkg::REG_ZERO:   thresh_in.zero_thr   = csr_pwdata[15:0];
            default:               thresh_in = thresh_ff;
         endcase
      end
   end

   // Read data is a plain decode of the register index.
   always_comb begin
      unique case (csr_index)
         irpwd_pkg::REG_START:  csr_prdata = {16'd0, thresh_ff.start_thr};
         irpwd_pkg::REG_REPEAT: csr_prdata = {16'd0, thresh_ff.repeat_thr};
         irpwd_pkg::REG_ONE:    csr_prdata = {16'd0, thresh_ff.one_thr};
         irpwd_pkg::REG_ZERO:   csr_prdata = {16'd0, thresh_ff.zero_thr};
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.start_thr  <= irpwd_pkg::START_THR_RESET;
         thresh_ff.repeat_thr <= irpwd_pkg::REPEAT_THR_RESET;
         thresh_ff.one_thr    <= irpwd_pkg::ONE_THR_RESET;
         thresh_ff.zero_thr   <= irpwd_pkg::ZERO_THR_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   // The front classifies each request and tracks frame position.
   irpwd_front #(
      .FRAME_BITS (FRAME_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .thresh     (thresh_ff),
      .push_token (push_token),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .status     (front_status)
   );

   // The queue lets the front keep accepting while a result is stalled.
   irpwd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_token (push_token),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_token  (pop_token),
      .pop        (pop)
   );

   // The back assembles the command byte and drives the result register.
   irpwd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_token (pop_token),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

   // Only a command result may carry a nonzero command byte.
   `IRPWD_ASSERT_SAME(a_cmd_zero, clock, reset,
      rsp_ch.valid && (rsp_ch.kind != irpwd_pkg::KIND_COMMAND), rsp_ch.command == '0)

   // Accepting the last data bit of a frame returns the front to idle.
   `IRPWD_ASSERT_NEXT(a_frame_ends, clock, reset,
      req_ch.valid && req_ch.ready && front_status.in_frame && front_status.last_bit,
      !front_status.in_frame)

   // A repeat token is only ever produced while no frame is open.
   `IRPWD_ASSERT_SAME(a_repeat_idle, clock, reset,
      push_valid && (push_token.kind == irpwd_pkg::TOK_REPEAT), !front_status.in_frame)

endmodule
`default_nettype wire
